@@ hdl/scanline_span_builder_defines.svh @@
// Assertion macros used by the span builder RTL.
// Each check is sampled on the rising edge of clk and held off while arst_n is low.
`ifndef SCANLINE_SPAN_BUILDER_DEFINES_SVH
`define SCANLINE_SPAN_BUILDER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SSB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define SSB_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define SSB_ASSERT(lbl, prop, msg)
`define SSB_NEVER(lbl, expr, msg)
`endif

`endif

@@ hdl/ssb_pkg.sv @@
package ssb_pkg;

	typedef struct packed {
		logic ins;
		logic shift;
	} ssb_chain_ctl_t;

	typedef struct packed {
		logic step;
		logic flush_open;
		logic flush_last;
	} ssb_merge_ctl_t;

endpackage

@@ hdl/ssb_sort_cell.sv @@
module ssb_sort_cell
	import ssb_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ssb_chain_ctl_t               ctl,
	input  logic signed [COORD_BITS-1:0] new_val,
	input  logic signed [COORD_BITS-1:0] left_val,
	input  logic                         left_valid,
	input  logic                         left_gt,
	input  logic signed [COORD_BITS-1:0] right_val,
	input  logic                         right_valid,
	output logic signed [COORD_BITS-1:0] val,
	output logic                         valid,
	output logic                         gt
);

	logic signed [COORD_BITS-1:0] val_q;
	logic                         valid_q;

	// An empty cell counts as larger than any coordinate.
	assign gt    = !valid_q || (val_q > new_val);
	assign val   = val_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= right_valid;
		end else if (ctl.ins && gt) begin
			valid_q <= left_gt ? left_valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			val_q <= right_val;
		end else if (ctl.ins && gt) begin
			val_q <= left_gt ? left_val : new_val;
		end
	end

endmodule

@@ hdl/ssb_sort_chain.sv @@
module ssb_sort_chain
	import ssb_pkg::*;
#(
	parameter int MAX_PAIRS  = 32,
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ssb_chain_ctl_t               ctl,
	input  logic signed [COORD_BITS-1:0] new_val,
	output logic signed [COORD_BITS-1:0] head_val
);

	logic signed [COORD_BITS-1:0] vals   [MAX_PAIRS];
	logic                         valids [MAX_PAIRS];
	logic                         gts    [MAX_PAIRS];

	for (genvar i = 0; i < MAX_PAIRS; i++) begin : g_cell
		logic signed [COORD_BITS-1:0] lv;
		logic                         lvalid;
		logic                         lgt;
		logic signed [COORD_BITS-1:0] rv;
		logic                         rvalid;

		if (i == 0) begin : g_first
			assign lv     = new_val;
			assign lvalid = 1'b0;
			assign lgt    = 1'b0;
		end else begin : g_inner_l
			assign lv     = vals[i-1];
			assign lvalid = valids[i-1];
			assign lgt    = gts[i-1];
		end

		if (i == MAX_PAIRS - 1) begin : g_last
			assign rv     = new_val;
			assign rvalid = 1'b0;
		end else begin : g_inner_r
			assign rv     = vals[i+1];
			assign rvalid = valids[i+1];
		end

		ssb_sort_cell #(
			.COORD_BITS(COORD_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.new_val    (new_val),
			.left_val   (lv),
			.left_valid (lvalid),
			.left_gt    (lgt),
			.right_val  (rv),
			.right_valid(rvalid),
			.val        (vals[i]),
			.valid      (valids[i]),
			.gt         (gts[i])
		);
	end

	assign head_val = vals[0];

endmodule

@@ hdl/ssb_merge.sv @@
module ssb_merge
	import ssb_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ssb_merge_ctl_t               ctl,
	input  logic signed [COORD_BITS-1:0] enter_val,
	input  logic signed [COORD_BITS-1:0] exit_val,
	output logic                         result_valid,
	output logic signed [COORD_BITS-1:0] span_begin,
	output logic signed [COORD_BITS-1:0] span_end,
	output logic                         span_valid,
	output logic                         last_span
);

	logic                         open_q;
	logic                         pend_q;
	logic signed [COORD_BITS-1:0] cb_q;
	logic signed [COORD_BITS-1:0] ce_q;
	logic signed [COORD_BITS-1:0] pb_q;
	logic signed [COORD_BITS-1:0] pe_q;
	logic                         strobe_q;
	logic signed [COORD_BITS-1:0] ob_q;
	logic signed [COORD_BITS-1:0] oe_q;
	logic                         ov_q;
	logic                         ol_q;

	logic merge_in;
	logic close_span;

	assign merge_in   = ctl.step && open_q && (enter_val <= ce_q);
	assign close_span = open_q && ((ctl.step && !merge_in) || ctl.flush_open);

	// A closed span waits in the pending register until the next span closes or the last
	// flush, so that the final one can still be marked as last.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q   <= 1'b0;
			pend_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (close_span && pend_q) || ctl.flush_last;
			if (ctl.flush_last) begin
				pend_q <= 1'b0;
			end else if (close_span) begin
				pend_q <= 1'b1;
			end
			if (ctl.flush_open) begin
				open_q <= 1'b0;
			end else if (ctl.step && !merge_in) begin
				open_q <= (enter_val != exit_val);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (merge_in) begin
			if (exit_val > ce_q) begin
				ce_q <= exit_val;
			end
		end else if (ctl.step) begin
			cb_q <= enter_val;
			ce_q <= exit_val;
		end
		if (close_span) begin
			pb_q <= cb_q;
			pe_q <= ce_q;
		end
		if (ctl.flush_last) begin
			ob_q <= pend_q ? pb_q : '0;
			oe_q <= pend_q ? pe_q : '0;
			ov_q <= pend_q;
			ol_q <= 1'b1;
		end else if (close_span) begin
			ob_q <= pb_q;
			oe_q <= pe_q;
			ov_q <= 1'b1;
			ol_q <= 1'b0;
		end
	end

	assign result_valid = strobe_q;
	assign span_begin   = ob_q;
	assign span_end     = oe_q;
	assign span_valid   = ov_q;
	assign last_span    = ol_q;

endmodule

@@ hdl/scanline_span_builder.sv @@
// Channel   Transfer when          Fields
// input     start && !busy         enter_pos, exit_pos, last_pair
// result    result_valid           span_begin, span_end, span_valid, last_span
//
// Both sort chains insert an accepted pair in the cycle it is accepted; once they hold
// MAX_PAIRS pairs, further pairs are dropped. After a closing pair, busy stays high
// while the chains shift out one sorted pair per cycle into the merge unit, then while
// the flush states flush the open and pending spans. Reset clears the cell valid
// bits and all control state. Results cannot be stalled; each one is shown for one cycle.
`include "scanline_span_builder_defines.svh"

module scanline_span_builder
	import ssb_pkg::*;
#(
	parameter int MAX_PAIRS  = 32,
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COORD_BITS-1:0] enter_pos,
	input  logic signed [COORD_BITS-1:0] exit_pos,
	input  logic                         last_pair,
	output logic                         result_valid,
	output logic signed [COORD_BITS-1:0] span_begin,
	output logic signed [COORD_BITS-1:0] span_end,
	output logic                         span_valid,
	output logic                         last_span
);

	localparam int CW = $clog2(MAX_PAIRS + 1);
	localparam logic [CW-1:0] FULL = CW'(MAX_PAIRS);
	localparam logic [CW-1:0] ONE  = CW'(1);

	typedef enum logic [1:0] {
		ST_COLLECT,
		ST_DRAIN,
		ST_FLUSH_OPEN,
		ST_FLUSH_LAST
	} state_t;

	state_t         state_q;
	logic [CW-1:0]  count_q;
	logic [CW-1:0]  drain_q;
	logic           accept;
	logic           store;
	ssb_chain_ctl_t chain_ctl;
	ssb_merge_ctl_t merge_ctl;
	logic signed [COORD_BITS-1:0] enter_head;
	logic signed [COORD_BITS-1:0] exit_head;

	assign busy   = (state_q != ST_COLLECT);
	assign accept = start && !busy;
	assign store  = accept && (count_q != FULL);

	assign chain_ctl.ins   = store;
	assign chain_ctl.shift = (state_q == ST_DRAIN);

	assign merge_ctl.step       = (state_q == ST_DRAIN);
	assign merge_ctl.flush_open = (state_q == ST_FLUSH_OPEN);
	assign merge_ctl.flush_last = (state_q == ST_FLUSH_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
			count_q <= '0;
			drain_q <= '0;
		end else begin
			unique case (state_q)
				ST_COLLECT: begin
					if (accept && last_pair) begin
						state_q <= ST_DRAIN;
						drain_q <= store ? count_q + ONE : count_q;
						count_q <= '0;
					end else if (store) begin
						count_q <= count_q + ONE;
					end
				end
				ST_DRAIN: begin
					drain_q <= drain_q - ONE;
					if (drain_q == ONE) begin
						state_q <= ST_FLUSH_OPEN;
					end
				end
				ST_FLUSH_OPEN: begin
					state_q <= ST_FLUSH_LAST;
				end
				ST_FLUSH_LAST: begin
					state_q <= ST_COLLECT;
				end
				default: begin
					state_q <= ST_COLLECT;
				end
			endcase
		end
	end

	ssb_sort_chain #(
		.MAX_PAIRS (MAX_PAIRS),
		.COORD_BITS(COORD_BITS)
	) u_enter_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (chain_ctl),
		.new_val (enter_pos),
		.head_val(enter_head)
	);

	ssb_sort_chain #(
		.MAX_PAIRS (MAX_PAIRS),
		.COORD_BITS(COORD_BITS)
	) u_exit_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (chain_ctl),
		.new_val (exit_pos),
		.head_val(exit_head)
	);

	ssb_merge #(
		.COORD_BITS(COORD_BITS)
	) u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (merge_ctl),
		.enter_val   (enter_head),
		.exit_val    (exit_head),
		.result_valid(result_valid),
		.span_begin  (span_begin),
		.span_end    (span_end),
		.span_valid  (span_valid),
		.last_span   (last_span)
	);

	`SSB_ASSERT(a_last_ends_line, result_valid && last_span |-> !busy, "last span while busy")
	`SSB_ASSERT(a_inner_while_busy, result_valid && !last_span |-> busy, "inner span while idle")
	`SSB_ASSERT(a_empty_is_last, result_valid && !span_valid |-> last_span, "empty result not last")
	`SSB_NEVER(a_drain_nonzero, state_q == ST_DRAIN && drain_q == '0, "drain count ran out")

endmodule
